>>> sv/roi_gray_world_white_balance_loop_assert.svh
// Assertion macros used by the white balance RTL.
`ifndef ROI_GRAY_WORLD_WHITE_BALANCE_LOOP_ASSERT_SVH
`define ROI_GRAY_WORLD_WHITE_BALANCE_LOOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RGWB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RGWB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGWB_ASSERT(lbl, clk, rst_n, prop, msg)
`define RGWB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/rgwb_pkg.sv
`timescale 1ns / 1ps
package rgwb_pkg;

  localparam int MAX_IMAGE_SIZE = 2048;
  localparam int SUM_W          = 30;
  localparam int CNT_W          = 23;
  localparam int GAIN_STEP      = 100;
  localparam int GAIN_CAP       = 1024;

  localparam logic [10:0] BLUE_LEVEL_RST = 11'd700;
  localparam logic [10:0] RED_LEVEL_RST  = 11'd512;
  localparam logic [11:0] ROW_START_RST  = 12'd0;
  localparam logic [11:0] ROW_END_RST    = 12'd2048;
  localparam logic [11:0] COL_START_RST  = 12'd0;
  localparam logic [11:0] COL_END_RST    = 12'd2048;
  localparam logic [7:0]  SKIP_RST       = 8'd10;
  localparam logic [9:0]  CORR_RST       = 10'd256;

  // last quotient bit index for each kind of division
  localparam logic [3:0] DIV_MEAN_TOP = 4'd7;
  localparam logic [3:0] DIV_GAIN_TOP = 4'd11;

  typedef enum logic [2:0] {
    CFG_ROW_START = 3'd0,
    CFG_ROW_END   = 3'd1,
    CFG_COL_START = 3'd2,
    CFG_COL_END   = 3'd3,
    CFG_SKIP      = 3'd4,
    CFG_BLUE_CORR = 3'd5,
    CFG_RED_CORR  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [10:0] row;
    logic [10:0] column;
    logic        frame_end;
  } pix_t;

  typedef struct packed {
    logic [10:0] blue_gain;
    logic [10:0] red_gain;
    logic        region_empty;
  } gains_t;

  typedef struct packed {
    logic        start;
    logic [29:0] dividend;
    logic [29:0] divisor;
    logic [3:0]  top;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [11:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/rgwb_div.sv
`timescale 1ns / 1ps
module rgwb_div
  import rgwb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [29:0] rem_r;
  logic [29:0] dsr_r;
  logic [11:0] q_r;
  logic [3:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [30:0] diff;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign diff = {1'b0, rem_r} - {1'b0, dsr_r};
  assign ge   = ~diff[30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= req.top;
      end else if (run_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsr_r <= req.divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[29:0] : rem_r;
      dsr_r <= dsr_r >> 1;
      q_r   <= {q_r[10:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

>>> sv/roi_gray_world_white_balance_loop.sv
`timescale 1ns / 1ps
// Pixels are taken one per clock while the block is idle; a skipped frame end
// also leaves the input free. An updating frame end stalls the input after its
// transaction: three 8-bit mean divisions, two gain passes around a 12-bit division
// and the result load, after which the result is valid. A zero blue or red mean skips
// the gain division of that channel, an empty region skips all divisions.
// Synchronous active-low reset: sums clear, frame counter all ones, levels 700/512.
module roi_gray_world_white_balance_loop
  import rgwb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pix_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gains_t      out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  `include "roi_gray_world_white_balance_loop_assert.svh"

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MEAN = 6'b000010,
    S_GK   = 6'b000100,
    S_LX   = 6'b001000,
    S_GDIV = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [11:0] row_start_r, row_end_r, col_start_r, col_end_r;
  logic [7:0]  skip_r;
  logic [9:0]  blue_corr_r, red_corr_r;

  logic [SUM_W-1:0] blue_sum_r, green_sum_r, red_sum_r;
  logic [CNT_W-1:0] pixel_count_r;
  logic [7:0]       frame_cnt_r;
  logic [10:0]      blue_level_r, red_level_r;
  logic [7:0]       mean_b_r, mean_g_r, mean_red_r;
  logic [1:0]       ch_r;
  logic             gsel_r;
  logic [17:0]      prod_r;
  logic             empty_r;
  logic             out_valid_r;
  gains_t           out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_acc, cfg_acc, in_range, skip_frame, upd_frame, out_free;
  logic [SUM_W:0]   blue_add, green_add, red_add;
  logic [CNT_W:0]   cnt_add;
  logic [SUM_W-1:0] blue_acc, green_acc, red_acc;
  logic [CNT_W-1:0] count_acc;

  logic [10:0] lvl;
  logic [7:0]  cmean;
  logic [9:0]  corr;
  logic [18:0] xval;
  logic [10:0] mul_a;
  logic [18:0] mul_b;
  logic [29:0] mul_p;
  logic [11:0] hi, lo, cand;
  logic [10:0] new_level;

  rgwb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // accumulation path
  always_comb begin
    in_range = ({3'b0, in_data.row} < 14'(MAX_IMAGE_SIZE)) &&
               ({3'b0, in_data.column} < 14'(MAX_IMAGE_SIZE)) &&
               ({1'b0, in_data.row} >= row_start_r) &&
               ({1'b0, in_data.row} < row_end_r) &&
               ({1'b0, in_data.column} >= col_start_r) &&
               ({1'b0, in_data.column} < col_end_r);
    blue_add  = {1'b0, blue_sum_r} + {23'b0, in_data.blue};
    green_add = {1'b0, green_sum_r} + {23'b0, in_data.green};
    red_add   = {1'b0, red_sum_r} + {23'b0, in_data.red};
    cnt_add   = {1'b0, pixel_count_r} + {{CNT_W{1'b0}}, 1'b1};
    blue_acc  = blue_sum_r;
    green_acc = green_sum_r;
    red_acc   = red_sum_r;
    count_acc = pixel_count_r;
    if (in_range) begin
      blue_acc  = blue_add[SUM_W] ? '1 : blue_add[SUM_W-1:0];
      green_acc = green_add[SUM_W] ? '1 : green_add[SUM_W-1:0];
      red_acc   = red_add[SUM_W] ? '1 : red_add[SUM_W-1:0];
      count_acc = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
    end
    skip_frame = in_acc && in_data.frame_end && (frame_cnt_r < skip_r);
    upd_frame  = in_acc && in_data.frame_end && !(frame_cnt_r < skip_r);
  end

  // shared multiplier and gain clamp
  always_comb begin
    lvl   = gsel_r ? red_level_r : blue_level_r;
    cmean = gsel_r ? mean_red_r : mean_b_r;
    corr  = gsel_r ? red_corr_r : blue_corr_r;
    xval  = {3'b0, cmean, 8'b0} + {1'b0, prod_r};
    mul_a = (state_r == S_GK) ? {3'b0, mean_g_r} : lvl;
    mul_b = (state_r == S_GK) ? {9'b0, corr} : xval;
    mul_p = mul_a * mul_b;
    hi    = {1'b0, lvl} + 12'(GAIN_STEP);
    lo    = {1'b0, lvl} - 12'(GAIN_STEP);
    if (state_r == S_GK) begin
      cand = hi;
    end else if (div_rsp.quotient[11] || (div_rsp.quotient > hi)) begin
      cand = hi;
    end else if ((lvl >= 11'(GAIN_STEP)) && (div_rsp.quotient < lo)) begin
      cand = lo;
    end else begin
      cand = div_rsp.quotient;
    end
    new_level = (cand > 12'(GAIN_CAP)) ? 11'(GAIN_CAP) : cand[10:0];
  end

  // divider requests
  always_comb begin
    div_req          = '0;
    div_req.divisor  = {pixel_count_r, 7'b0};
    div_req.top      = DIV_MEAN_TOP;
    div_req.dividend = (ch_r == 2'd0) ? green_sum_r : red_sum_r;
    unique case (state_r)
      S_IDLE: begin
        div_req.start    = upd_frame && (count_acc != '0);
        div_req.dividend = blue_acc;
        div_req.divisor  = {count_acc, 7'b0};
      end
      S_MEAN: begin
        div_req.start = div_rsp.done && (ch_r != 2'd2);
      end
      S_LX: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p;
        div_req.divisor  = {2'b0, cmean, 20'b0};
        div_req.top      = DIV_GAIN_TOP;
      end
      S_GK, S_GDIV, S_DONE: begin
        div_req.start = 1'b0;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (upd_frame) begin
          state_nxt = (count_acc == '0) ? S_DONE : S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_rsp.done && (ch_r == 2'd2)) begin
          state_nxt = S_GK;
        end
      end
      S_GK: begin
        if (cmean != '0) begin
          state_nxt = S_LX;
        end else if (gsel_r) begin
          state_nxt = S_DONE;
        end
      end
      S_LX: begin
        state_nxt = S_GDIV;
      end
      S_GDIV: begin
        if (div_rsp.done) begin
          state_nxt = gsel_r ? S_DONE : S_GK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_start_r <= ROW_START_RST;
      row_end_r   <= ROW_END_RST;
      col_start_r <= COL_START_RST;
      col_end_r   <= COL_END_RST;
      skip_r      <= SKIP_RST;
      blue_corr_r <= CORR_RST;
      red_corr_r  <= CORR_RST;
      blue_sum_r    <= '0;
      green_sum_r   <= '0;
      red_sum_r     <= '0;
      pixel_count_r <= '0;
      frame_cnt_r   <= '1;
      blue_level_r  <= BLUE_LEVEL_RST;
      red_level_r   <= RED_LEVEL_RST;
      ch_r          <= '0;
      gsel_r        <= 1'b0;
      empty_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_ROW_START: row_start_r <= cfg_data;
          CFG_ROW_END:   row_end_r   <= cfg_data;
          CFG_COL_START: col_start_r <= cfg_data;
          CFG_COL_END:   col_end_r   <= cfg_data;
          CFG_SKIP:      skip_r      <= cfg_data[7:0];
          CFG_BLUE_CORR: blue_corr_r <= cfg_data[9:0];
          CFG_RED_CORR:  red_corr_r  <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (skip_frame || ((state_r == S_DONE) && out_free)) begin
        blue_sum_r    <= '0;
        green_sum_r   <= '0;
        red_sum_r     <= '0;
        pixel_count_r <= '0;
      end else if (in_acc) begin
        blue_sum_r    <= blue_acc;
        green_sum_r   <= green_acc;
        red_sum_r     <= red_acc;
        pixel_count_r <= count_acc;
      end

      if (skip_frame) begin
        frame_cnt_r <= frame_cnt_r + 8'd1;
      end else if (upd_frame) begin
        frame_cnt_r <= '0;
      end

      if (upd_frame) begin
        empty_r <= (count_acc == '0);
        ch_r    <= '0;
        gsel_r  <= 1'b0;
      end

      if ((state_r == S_MEAN) && div_rsp.done) begin
        ch_r <= ch_r + 2'd1;
      end

      if (((state_r == S_GK) && (cmean == '0)) ||
          ((state_r == S_GDIV) && div_rsp.done)) begin
        if (gsel_r) begin
          red_level_r <= new_level;
        end else begin
          blue_level_r <= new_level;
        end
        gsel_r <= 1'b1;
      end

      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_MEAN) && div_rsp.done) begin
      case (ch_r)
        2'd0:    mean_b_r   <= div_rsp.quotient[7:0];
        2'd1:    mean_g_r   <= div_rsp.quotient[7:0];
        default: mean_red_r <= div_rsp.quotient[7:0];
      endcase
    end
    if (state_r == S_GK) begin
      prod_r <= mul_p[17:0];
    end
    if ((state_r == S_DONE) && out_free) begin
      out_data_r.blue_gain    <= blue_level_r;
      out_data_r.red_gain     <= red_level_r;
      out_data_r.region_empty <= empty_r;
    end
  end

  `RGWB_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result raised outside completion")
  `RGWB_ASSERT(a_div_done_owner, clk, rst_n, div_rsp.done |-> (state_r == S_MEAN || state_r == S_GDIV), "divider finished with no owner")
  `RGWB_ASSERT(a_sums_cleared, clk, rst_n, (state_r == S_DONE && out_free) |=> (pixel_count_r == '0 && blue_sum_r == '0), "sums not cleared after update")
  `RGWB_ASSERT(a_level_cap, clk, rst_n, (blue_level_r <= 11'(GAIN_CAP)) && (red_level_r <= 11'(GAIN_CAP)), "gain level above cap")
  `RGWB_ASSERT(a_hold_result, clk, rst_n, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)), "stalled transaction lost")

endmodule

>>> tb/sv/roi_gray_world_white_balance_loop_tb.sv
`timescale 1ns / 1ps
module roi_gray_world_white_balance_loop_tb;
  import rgwb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_ITEMS   = 700;

  localparam logic [SUM_W-1:0] SUM_FULL   = '1;
  localparam logic [CNT_W-1:0] COUNT_FULL = '1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pix_t        in_data;
  logic        out_valid;
  logic        out_stall;
  gains_t      out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  roi_gray_world_white_balance_loop u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Gain tracker state, mirrors the block
  logic [11:0]      roi_row_lo = ROW_START_RST;
  logic [11:0]      roi_row_hi = ROW_END_RST;
  logic [11:0]      roi_col_lo = COL_START_RST;
  logic [11:0]      roi_col_hi = COL_END_RST;
  logic [7:0]       skip_cfg   = SKIP_RST;
  logic [9:0]       corr_blue  = CORR_RST;
  logic [9:0]       corr_red   = CORR_RST;
  logic [SUM_W-1:0] acc_blue   = '0;
  logic [SUM_W-1:0] acc_green  = '0;
  logic [SUM_W-1:0] acc_red    = '0;
  logic [CNT_W-1:0] acc_count  = '0;
  logic [7:0]       frames_seen = 8'hFF;
  logic [10:0]      lvl_blue   = BLUE_LEVEL_RST;
  logic [10:0]      lvl_red    = RED_LEVEL_RST;

  gains_t gains_q[$];
  gains_t exp_gains;

  int  mismatches    = 0;
  int  pixels_sent   = 0;
  int  random_pixels = 0;
  int  gains_checked = 0;
  int  empty_reports = 0;
  int  reg_writes    = 0;
  int  settings_used = 0;
  int  idle_cycles   = 0;
  int  gap_pct       = 0;
  int  stall_pct     = 0;
  bit  hold_req      = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic pix_t mk_pix(input logic [7:0] b, input logic [7:0] g,
                                  input logic [7:0] r, input logic [10:0] row,
                                  input logic [10:0] col, input logic fe);
    pix_t p;
    p.blue = b;
    p.green = g;
    p.red = r;
    p.row = row;
    p.column = col;
    p.frame_end = fe;
    return p;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [7:0] v);
    return (a > SUM_FULL - v) ? SUM_FULL : a + v;
  endfunction

  function automatic logic [10:0] damp_gain(input logic [10:0] lvl,
                                            input logic [7:0] g_mean,
                                            input logic [7:0] c_mean,
                                            input logic [9:0] corr);
    longint unsigned lv, num, den, nxt;
    lv = 64'(lvl);
    if (c_mean == 0) begin
      nxt = lv + GAIN_STEP;
    end else begin
      num = lv * (64'(c_mean) * 256 + 64'(g_mean) * 64'(corr));
      den = 64'(c_mean) * 512;
      if (num > (lv + GAIN_STEP) * den) begin
        nxt = lv + GAIN_STEP;
      end else if (lv * den > num && lv * den - num > GAIN_STEP * den) begin
        nxt = lv - GAIN_STEP;
      end else begin
        nxt = num / den;
      end
    end
    if (nxt > GAIN_CAP) nxt = GAIN_CAP;
    return nxt[10:0];
  endfunction

  function automatic void clear_sums();
    acc_blue = '0;
    acc_green = '0;
    acc_red = '0;
    acc_count = '0;
  endfunction

  function automatic void track_pixel(input pix_t p);
    logic [31:0] mb, mg, mr;
    gains_t res;
    if (p.row >= roi_row_lo && p.row < roi_row_hi &&
        p.column >= roi_col_lo && p.column < roi_col_hi) begin
      acc_blue = sat_sum(acc_blue, p.blue);
      acc_green = sat_sum(acc_green, p.green);
      acc_red = sat_sum(acc_red, p.red);
      if (acc_count != COUNT_FULL) acc_count = acc_count + 1'b1;
    end
    if (!p.frame_end) return;
    if (frames_seen < skip_cfg) begin
      frames_seen = frames_seen + 1'b1;
      clear_sums();
      return;
    end
    frames_seen = '0;
    res.region_empty = (acc_count == 0);
    if (!res.region_empty) begin
      mb = 32'(acc_blue) / 32'(acc_count);
      mg = 32'(acc_green) / 32'(acc_count);
      mr = 32'(acc_red) / 32'(acc_count);
      lvl_blue = damp_gain(lvl_blue, mg[7:0], mb[7:0], corr_blue);
      lvl_red = damp_gain(lvl_red, mg[7:0], mr[7:0], corr_red);
    end
    clear_sums();
    res.blue_gain = lvl_blue;
    res.red_gain = lvl_red;
    gains_q.push_back(res);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic push_pixel(input pix_t p);
    int n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = pick_gap();
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_pixel(p);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (gains_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROW_START: roi_row_lo = val;
      CFG_ROW_END:   roi_row_hi = val;
      CFG_COL_START: roi_col_lo = val;
      CFG_COL_END:   roi_col_hi = val;
      CFG_SKIP:      skip_cfg = val[7:0];
      CFG_BLUE_CORR: corr_blue = val[9:0];
      CFG_RED_CORR:  corr_red = val[9:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [11:0] rs, input logic [11:0] re,
                          input logic [11:0] cs, input logic [11:0] ce,
                          input logic [11:0] skip, input logic [11:0] kb,
                          input logic [11:0] kr);
    write_reg(CFG_ROW_START, rs);
    write_reg(CFG_ROW_END, re);
    write_reg(CFG_COL_START, cs);
    write_reg(CFG_COL_END, ce);
    write_reg(CFG_SKIP, skip);
    write_reg(CFG_BLUE_CORR, kb);
    write_reg(CFG_RED_CORR, kr);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gains_q.size() == 0) begin
        flag_mismatch("unexpected result", int'(out_data.blue_gain), -1);
      end else begin
        exp_gains = gains_q.pop_front();
        if (out_data.blue_gain !== exp_gains.blue_gain)
          flag_mismatch("blue_gain", int'(out_data.blue_gain),
                        int'(exp_gains.blue_gain));
        if (out_data.red_gain !== exp_gains.red_gain)
          flag_mismatch("red_gain", int'(out_data.red_gain),
                        int'(exp_gains.red_gain));
        if (out_data.region_empty !== exp_gains.region_empty)
          flag_mismatch("region_empty", int'(out_data.region_empty),
                        int'(exp_gains.region_empty));
        gains_checked++;
        if (exp_gains.region_empty) empty_reports++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        n = pick_gap();
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_reset_update();
    push_pixel(mk_pix(8'd0, 8'd255, 8'd255, 11'd0, 11'd0, 1'b0));
    push_pixel(mk_pix(8'd255, 8'd0, 8'd0, 11'd2047, 11'd2047, 1'b1));
    wait_idle();
  endtask

  task automatic test_zero_mean();
    set_regs(12'd0, 12'd2048, 12'd0, 12'd2048, 12'd0, 12'd256, 12'd256);
    push_pixel(mk_pix(8'd0, 8'd200, 8'd0, 11'd3, 11'd9, 1'b1));
    wait_idle();
  endtask

  task automatic test_step_down();
    push_pixel(mk_pix(8'd255, 8'd1, 8'd255, 11'd1024, 11'd512, 1'b1));
    wait_idle();
  endtask

  task automatic test_gain_cap();
    set_regs(12'd0, 12'd2048, 12'd0, 12'd2048, 12'd0, 12'd1023, 12'd1023);
    repeat (6) push_pixel(mk_pix(8'd1, 8'd255, 8'd0, 11'd700, 11'd1365, 1'b1));
    wait_idle();
  endtask

  task automatic test_roi_edges();
    set_regs(12'd5, 12'd6, 12'd7, 12'd8, 12'd0, 12'd256, 12'd256);
    push_pixel(mk_pix(8'd40, 8'd90, 8'd60, 11'd5, 11'd7, 1'b0));
    push_pixel(mk_pix(8'd255, 8'd0, 8'd255, 11'd6, 11'd7, 1'b0));
    push_pixel(mk_pix(8'd255, 8'd0, 8'd255, 11'd4, 11'd7, 1'b0));
    push_pixel(mk_pix(8'd255, 8'd0, 8'd255, 11'd5, 11'd8, 1'b0));
    push_pixel(mk_pix(8'd255, 8'd0, 8'd255, 11'd5, 11'd6, 1'b1));
    wait_idle();
  endtask

  task automatic test_empty_region();
    set_regs(12'd100, 12'd50, 12'd0, 12'd2048, 12'd0, 12'd256, 12'd256);
    push_pixel(mk_pix(8'd10, 8'd20, 8'd30, 11'd75, 11'd75, 1'b1));
    wait_idle();
    set_regs(12'd0, 12'd2048, 12'd2048, 12'd2048, 12'd0, 12'd256, 12'd256);
    push_pixel(mk_pix(8'd10, 8'd20, 8'd30, 11'd2047, 11'd2047, 1'b1));
    wait_idle();
  endtask

  task automatic test_zero_correction();
    set_regs(12'd0, 12'd2048, 12'd0, 12'd2048, 12'd0, 12'd0, 12'd0);
    push_pixel(mk_pix(8'd128, 8'd128, 8'd128, 11'd1, 11'd2, 1'b1));
    wait_idle();
  endtask

  task automatic test_skip_count();
    set_regs(12'd0, 12'd2048, 12'd0, 12'd2048, 12'd2, 12'd256, 12'd256);
    push_pixel(mk_pix(8'd50, 8'd100, 8'd70, 11'd10, 11'd10, 1'b1));
    push_pixel(mk_pix(8'd90, 8'd100, 8'd20, 11'd10, 11'd10, 1'b1));
    push_pixel(mk_pix(8'd60, 8'd110, 8'd80, 11'd10, 11'd10, 1'b1));
    wait_idle();
  endtask

  task automatic test_back_pressure();
    stall_pct = 0;
    gap_pct = 0;
    set_regs(12'd0, 12'd2048, 12'd0, 12'd2048, 12'd0, 12'd256, 12'd256);
    hold_req = 1'b1;
    repeat (2) @(negedge clk);
    for (int f = 0; f < 10; f++) begin
      push_pixel(mk_pix(8'($urandom), 8'($urandom), 8'($urandom),
                        11'($urandom), 11'($urandom), 1'b0));
      push_pixel(mk_pix(8'($urandom), 8'($urandom), 8'($urandom),
                        11'($urandom), 11'($urandom), 1'b1));
    end
    wait_idle();
  endtask

  task automatic pick_span(output logic [11:0] lo, output logic [11:0] hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = 12'd0;
        hi = 12'd2048;
      end
      1: begin
        lo = 12'($urandom_range(0, 2040));
        hi = lo + 12'($urandom_range(1, 8));
      end
      2: begin
        lo = 12'($urandom_range(1, 2048));
        hi = 12'($urandom_range(0, lo));
      end
      3: begin
        lo = 12'($urandom_range(2040, 2047));
        hi = 12'd2048;
      end
      default: begin
        lo = 12'($urandom_range(0, 2047));
        hi = 12'($urandom_range(lo + 1, 2048));
      end
    endcase
  endtask

  function automatic logic [10:0] pick_coord(input logic [11:0] lo, input logic [11:0] hi);
    if (hi > lo && $urandom_range(0, 4) != 0) return 11'($urandom_range(lo, hi - 1));
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [11:0] pick_corr();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd1023;
      2, 3, 4: return 12'($urandom_range(0, 1023));
      default: return 12'($urandom_range(192, 320));
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic test_random_frames();
    logic [11:0] rs, re, cs, ce, skip;
    logic [7:0]  base;
    int          n_frames, len, sel;
    pix_t        p;
    while (random_pixels < RANDOM_ITEMS) begin
      pick_span(rs, re);
      pick_span(cs, ce);
      sel = $urandom_range(0, 9);
      skip = (sel < 7) ? 12'd0 : (sel < 9) ? 12'($urandom_range(1, 3)) : 12'd255;
      n_frames = (skip == 12'd255) ? 2 : $urandom_range(3, 10);
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      set_regs(rs, re, cs, ce, skip, pick_corr(), pick_corr());
      repeat (n_frames) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
        base = 8'($urandom);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 1) != 0) begin
            p.blue = base ^ 8'($urandom_range(0, 31));
            p.green = base ^ 8'($urandom_range(0, 31));
            p.red = base ^ 8'($urandom_range(0, 31));
          end else begin
            p.blue = 8'($urandom);
            p.green = 8'($urandom);
            p.red = 8'($urandom);
          end
          p.row = pick_coord(rs, re);
          p.column = pick_coord(cs, ce);
          p.frame_end = (i == len - 1);
          push_pixel(p);
          random_pixels++;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_START;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    gap_pct = 20;
    stall_pct = 20;
    test_reset_update();
    test_zero_mean();
    test_step_down();
    test_gain_cap();
    test_roi_edges();
    test_empty_region();
    test_zero_correction();
    test_skip_count();
    test_back_pressure();
    test_random_frames();
    wait_idle();
    $display("Sent %0d pixels over %0d register settings (%0d writes).",
             pixels_sent, settings_used, reg_writes);
    $display("Checked %0d gain updates, %0d with an empty region; %0d mismatches.",
             gains_checked, empty_reports, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> roi_gray_world_white_balance_loop.f
+incdir+sv
sv/rgwb_pkg.sv
sv/rgwb_div.sv
sv/roi_gray_world_white_balance_loop.sv
tb/sv/roi_gray_world_white_balance_loop_tb.sv
